@@ rtl/gttf_pkg.sv @@
// Package for the guarded transition table state machine.
// Holds shared constants, action and compare codes, and the slot record type.
package gttf_pkg;
	localparam int NumSlotsDef    = 32;
	localparam int NumStatesDef   = 16;
	localparam int NumTriggersDef = 16;
	localparam int NumVarsDef     = 16;
	localparam logic [31:0] TimeMax = 32'h7fff_ffff;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_TRIGGER = 3'd1,
		ACT_JUMP    = 3'd2,
		ACT_SETVAR  = 3'd3,
		ACT_WRSLOT  = 3'd4,
		ACT_START   = 3'd5,
		ACT_NOP6    = 3'd6,
		ACT_NOP7    = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		CMP_LT = 3'd0, CMP_LE = 3'd1, CMP_GT = 3'd2, CMP_GE = 3'd3,
		CMP_NE = 3'd4, CMP_EQ = 3'd5, CMP_NONE = 3'd6, CMP_EQ7 = 3'd7
	} cmp_op_t;

	localparam logic [0:0] CfgInitialState = 1'b0;
	localparam logic [0:0] CfgStateCount   = 1'b1;

	typedef struct packed {
		logic [3:0]  src;
		logic [3:0]  dest;
		logic [4:0]  trig;
		logic [3:0]  var_idx;
		logic [2:0]  op;
		logic [31:0] value;
		logic [31:0] timeout;
	} slot_rec_t;

	// candidate hit latched while the cell row is scanned
	typedef struct packed {
		logic       hit;
		logic [3:0] dest;
		logic [4:0] trig;
	} scan_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} fsm_state_t;

	function automatic logic cmp_holds(input logic [2:0] op, input logic signed [31:0] lhs,
		input logic signed [31:0] rhs);
		logic r;
		unique case (op)
			CMP_LT:   r = lhs < rhs;
			CMP_LE:   r = lhs <= rhs;
			CMP_GT:   r = lhs > rhs;
			CMP_GE:   r = lhs >= rhs;
			CMP_NE:   r = lhs != rhs;
			CMP_NONE: r = 1'b1;
			default:  r = lhs == rhs;
		endcase
		return r;
	endfunction
endpackage

@@ rtl/gttf_cell.sv @@
// One cell of the slot row: holds one transition slot and its valid bit.
// Depends on gttf_pkg; hands the slot record to its neighbor on each shift.
module gttf_cell import gttf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  slot_rec_t wr_rec,
	input  logic      shift,
	input  logic      prev_valid,
	input  slot_rec_t prev_rec,
	output logic      valid,
	output slot_rec_t rec
);
	logic      valid_q;
	slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			rec_q <= wr_rec;
		end else if (shift) begin
			rec_q <= prev_rec;
		end
	end

	assign valid = valid_q;
	assign rec   = rec_q;
endmodule

@@ rtl/gttf_eval.sv @@
// Slot evaluator: tests the slot at the head of the row against the machine state.
// Depends on gttf_pkg; purely combinational.
module gttf_eval import gttf_pkg::*; #(
	parameter int NUM_TRIGGERS = NumTriggersDef,
	parameter int NUM_VARS     = NumVarsDef
) (
	input  logic                    valid,
	input  slot_rec_t               rec,
	input  logic [3:0]              active,
	input  logic [31:0]             tis,
	input  logic [NUM_TRIGGERS-1:0] pend,
	input  logic [31:0]             var_val,
	output logic                    hit
);
	logic trig_ok, time_ok, cmp_ok;
	always_comb begin
		trig_ok = 1'b1;
		for (int t = 0; t < NUM_TRIGGERS; t++) begin
			if (32'(rec.trig) == t) trig_ok = pend[t];
		end
		time_ok = rec.timeout[31] || (tis >= rec.timeout);
		cmp_ok  = cmp_holds(rec.op, (32'(rec.var_idx) < NUM_VARS) ? var_val : 32'd0,
			rec.value);
		hit = valid && (rec.src == active) && trig_ok && time_ok && cmp_ok;
	end
endmodule

@@ rtl/guarded_transition_table_fsm_core.sv @@
// Guarded transition table state machine. Each input transfer yields exactly one
// result transfer. An item other than a tick while running goes straight from the
// accepting cycle to the result; a tick while running first scans the slot table,
// which is a row of cells that rotates one slot per cycle past a single evaluator,
// and a full revolution is always made so the row returns to its home order. The
// first matching slot of the revolution is taken. The result waits while the
// receiver holds off m_tready. One item is in flight at a time; the result is held
// in the state registers until taken.
module guarded_transition_table_fsm_core import gttf_pkg::*; #(
	parameter int NUM_SLOTS    = NumSlotsDef,
	parameter int NUM_STATES   = NumStatesDef,
	parameter int NUM_TRIGGERS = NumTriggersDef,
	parameter int NUM_VARS     = NumVarsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[2:0] tick_amount[18:3] slot[23:19] state_id[27:24] dest_state[31:28]
	// trigger_id[36:32] var_index[40:37] compare_op[43:41] operand_value[75:44]
	// timeout[107:76], zero fill to 112
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// state_changed[0] current_state[4:1] running[5], zero fill to 8
	output logic [7:0]   m_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [4:0]   cfg_data
);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS + 1) : 1;

	// unpack the input transfer
	logic [2:0]  in_action;  logic [15:0] in_tick;  logic [4:0] in_slot;
	logic [3:0]  in_state;   logic [3:0]  in_dest;  logic [4:0] in_trig;
	logic [3:0]  in_var;     logic [2:0]  in_op;
	logic [31:0] in_value;   logic [31:0] in_timeout;
	assign in_action  = s_tdata[2:0];
	assign in_tick    = s_tdata[18:3];
	assign in_slot    = s_tdata[23:19];
	assign in_state   = s_tdata[27:24];
	assign in_dest    = s_tdata[31:28];
	assign in_trig    = s_tdata[36:32];
	assign in_var     = s_tdata[40:37];
	assign in_op      = s_tdata[43:41];
	assign in_value   = s_tdata[75:44];
	assign in_timeout = s_tdata[107:76];

	logic [3:0]  initial_state_q;
	logic [4:0]  state_count_q;
	logic [3:0]  active_q;
	logic        running_q;
	logic [31:0] tis_q;
	logic [NUM_TRIGGERS-1:0] pend_q;
	logic [31:0] vars_q [NUM_VARS];
	fsm_state_t  st_q, st_d;
	logic [SW-1:0] cnt_q;
	scan_t       cand_q;
	logic        changed_q;

	logic accept;
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// jump and start qualifiers
	logic jump_ok, start_ok;
	assign jump_ok  = ({1'b0, in_state} < state_count_q) && (32'(in_state) < NUM_STATES);
	assign start_ok = (state_count_q != 5'd0);

	// cell row: cell 0 is the head; each shift moves every slot one cell toward the head and the head slot to the tail
	logic      cell_valid [NUM_SLOTS];
	slot_rec_t cell_rec   [NUM_SLOTS];
	slot_rec_t wr_rec;
	logic      shift;
	assign wr_rec = '{src: in_state, dest: in_dest, trig: in_trig, var_idx: in_var,
		op: in_op, value: in_value, timeout: in_timeout};
	assign shift = (st_q == ST_SCAN);

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		localparam int Nx = (g + 1) % NUM_SLOTS;
		gttf_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr(accept && in_action == ACT_WRSLOT && 32'(in_slot) == g),
			.wr_rec(wr_rec), .shift(shift),
			.prev_valid(cell_valid[Nx]), .prev_rec(cell_rec[Nx]),
			.valid(cell_valid[g]), .rec(cell_rec[g])
		);
	end

	logic [31:0] var_val;
	logic        hit;
	always_comb begin
		var_val = 32'd0;
		for (int v = 0; v < NUM_VARS; v++) begin
			if (32'(cell_rec[0].var_idx) == v) var_val = vars_q[v];
		end
	end

	gttf_eval #(.NUM_TRIGGERS(NUM_TRIGGERS), .NUM_VARS(NUM_VARS)) u_eval (
		.valid(cell_valid[0]), .rec(cell_rec[0]), .active(active_q), .tis(tis_q),
		.pend(pend_q), .var_val(var_val), .hit(hit)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = (in_action == ACT_TICK && running_q) ? ST_SCAN : ST_OUT;
			ST_SCAN: if (cnt_q == SW'(NUM_SLOTS - 1)) st_d = ST_OUT;
			ST_OUT:  if (m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs: the state registers are settled on entry to ST_OUT and hold there
	always_comb begin
		m_tvalid = (st_q == ST_OUT);
		m_tdata  = {2'b00, running_q, active_q, changed_q};
	end

	logic [32:0] tis_sum;
	assign tis_sum = {1'b0, tis_q} + {17'd0, in_tick};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			initial_state_q <= '0; state_count_q <= '0;
			active_q <= '0; running_q <= 1'b0; tis_q <= '0; pend_q <= '0;
			for (int v = 0; v < NUM_VARS; v++) vars_q[v] <= '0;
			cnt_q <= '0; cand_q <= '0; changed_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CfgInitialState: initial_state_q <= cfg_data[3:0];
					CfgStateCount:   state_count_q   <= cfg_data;
				endcase
			end
			if (accept) begin
				changed_q <= (in_action == ACT_JUMP && jump_ok) ||
					(in_action == ACT_START && start_ok);
				cnt_q     <= '0;
				cand_q    <= '0;
				unique case (in_action)
					ACT_TICK: if (running_q)
						tis_q <= (tis_sum > {1'b0, TimeMax}) ? TimeMax : tis_sum[31:0];
					ACT_TRIGGER: for (int t = 0; t < NUM_TRIGGERS; t++)
						if (32'(in_trig) == t) pend_q[t] <= 1'b1;
					ACT_JUMP: if (jump_ok) begin
						active_q <= in_state; tis_q <= '0; running_q <= 1'b1;
					end
					ACT_SETVAR: for (int v = 0; v < NUM_VARS; v++)
						if (32'(in_var) == v) vars_q[v] <= in_value;
					ACT_START: if (start_ok) begin
						active_q <= initial_state_q; tis_q <= '0; running_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (st_q == ST_SCAN) begin
				cnt_q <= cnt_q + SW'(1);
				// latch the first hit; hold until the row is home
				if (hit && !cand_q.hit)
					cand_q <= '{hit: 1'b1, dest: cell_rec[0].dest, trig: cell_rec[0].trig};
				if (cnt_q == SW'(NUM_SLOTS - 1)) begin
					if (hit || cand_q.hit) begin
						changed_q <= 1'b1;
						running_q <= 1'b1;
						tis_q     <= '0;
						active_q  <= cand_q.hit ? cand_q.dest : cell_rec[0].dest;
						for (int t = 0; t < NUM_TRIGGERS; t++)
							if (32'(cand_q.hit ? cand_q.trig : cell_rec[0].trig) == t)
								pend_q[t] <= 1'b0;
					end
				end
			end
		end
	end

	a_scan_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> running_q) else $error("scan while stopped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && !m_tready) |=> (st_q == ST_OUT)) else $error("result dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("ready while result pending");
endmodule
